// ----- design/cpd_pkg.sv -----
`default_nettype none

package cpd_pkg;

   // result kinds
   localparam logic [2:0] KIND_HDR_OK  = 3'd0;
   localparam logic [2:0] KIND_PAYLOAD = 3'd1;
   localparam logic [2:0] KIND_PKT_OK  = 3'd2;
   localparam logic [2:0] KIND_HDR_ERR = 3'd3;
   localparam logic [2:0] KIND_PKT_ERR = 3'd4;

   // header check seed
   localparam logic [7:0] HDR_SEED = 8'h89;

   // frame byte positions
   localparam logic [8:0] POS_CHECK   = 9'd3;
   localparam logic [8:0] POS_PAYLOAD = 9'd4;

   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] dest_addr;
      logic [3:0] source_addr;
      logic [4:0] command;
      logic [1:0] ack_code;
      logic       request_flag;
      logic [7:0] payload_length;
      logic [7:0] payload_byte;
      logic       frame_end;
   } result_type;

endpackage

`default_nettype wire

// ----- design/cpd_parser.sv -----
`default_nettype none

module cpd_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [7:0]          rx_byte,
   output logic                     has_result,
   output cpd_pkg::result_type      result
);

   logic [8:0] pos_ff,  pos_in;
   logic [7:0] sum_ff,  sum_in;
   logic [7:0] hdr0_ff, hdr0_in;
   logic [7:0] hdr1_ff, hdr1_in;
   logic [7:0] hdr2_ff, hdr2_in;

   logic [7:0] check;
   logic [8:0] frame_last;
   logic [7:0] sum_add;

   assign check      = cpd_pkg::HDR_SEED + hdr0_ff + hdr1_ff + hdr2_ff;
   assign frame_last = {1'b0, hdr2_ff} + cpd_pkg::POS_PAYLOAD;
   assign sum_add    = sum_ff + rx_byte;

   always_comb begin
      pos_in  = pos_ff;
      sum_in  = sum_ff;
      hdr0_in = hdr0_ff;
      hdr1_in = hdr1_ff;
      hdr2_in = hdr2_ff;

      has_result            = 1'b0;
      result.kind           = cpd_pkg::KIND_HDR_OK;
      result.dest_addr      = hdr0_ff[3:0];
      result.source_addr    = hdr0_ff[7:4];
      result.command        = hdr1_ff[4:0];
      result.ack_code       = hdr1_ff[6:5];
      result.request_flag   = hdr1_ff[7];
      result.payload_length = hdr2_ff;
      result.payload_byte   = 8'd0;
      result.frame_end      = 1'b0;

      if (pos_ff < cpd_pkg::POS_CHECK) begin
         // header bytes: store and sum, nothing to report
         if (pos_ff[1:0] == 2'd0) hdr0_in = rx_byte;
         if (pos_ff[1:0] == 2'd1) hdr1_in = rx_byte;
         if (pos_ff[1:0] == 2'd2) hdr2_in = rx_byte;
         sum_in = sum_add;
         pos_in = pos_ff + 9'd1;
      end else if (pos_ff == cpd_pkg::POS_CHECK) begin
         has_result = 1'b1;
         if (rx_byte != check) begin
            result.kind           = cpd_pkg::KIND_HDR_ERR;
            result.dest_addr      = 4'd0;
            result.source_addr    = 4'd0;
            result.command        = 5'd0;
            result.ack_code       = 2'd0;
            result.request_flag   = 1'b0;
            result.payload_length = 8'd0;
            result.frame_end      = 1'b1;
            pos_in = 9'd0;
            sum_in = 8'd0;
         end else if (hdr2_ff == 8'd0) begin
            result.frame_end = 1'b1;
            pos_in = 9'd0;
            sum_in = 8'd0;
         end else begin
            sum_in = sum_add;
            pos_in = cpd_pkg::POS_PAYLOAD;
         end
      end else if (pos_ff < frame_last) begin
         has_result          = 1'b1;
         result.kind         = cpd_pkg::KIND_PAYLOAD;
         result.payload_byte = rx_byte;
         sum_in = sum_add;
         pos_in = pos_ff + 9'd1;
      end else begin
         has_result       = 1'b1;
         result.kind      = (rx_byte == sum_ff) ? cpd_pkg::KIND_PKT_OK
                                                : cpd_pkg::KIND_PKT_ERR;
         result.frame_end = 1'b1;
         pos_in = 9'd0;
         sum_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 9'd0;
         sum_ff  <= 8'd0;
         hdr0_ff <= 8'd0;
         hdr1_ff <= 8'd0;
         hdr2_ff <= 8'd0;
      end else if (step) begin
         pos_ff  <= pos_in;
         sum_ff  <= sum_in;
         hdr0_ff <= hdr0_in;
         hdr1_ff <= hdr1_in;
         hdr2_ff <= hdr2_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/cpd_out_reg.sv -----
`default_nettype none

module cpd_out_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire cpd_pkg::result_type load_data,
   output logic                     room,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output cpd_pkg::result_type      out_data
);

   logic                valid_ff, valid_in;
   cpd_pkg::result_type data_ff;

   // free when empty or being drained this cycle
   assign room      = !valid_ff || out_ready;
   assign valid_in  = load || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

`default_nettype wire

// ----- design/checksummed_packet_deframer_top.sv -----
// path: an accepted request goes through the input register, then the result register,
//   before its result shows on rsp_; header bytes 0 to 2 give no response
// throughput: one byte per cycle while the response side is not stalled
// reset: synchronous, active high; clears frame position, running sum, header
//   store and the valid flags of both register stages, the block then hunts for a new header
`default_nettype none

module checksummed_packet_deframer_top (
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   // response channel
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_kind,
   output logic [3:0]      rsp_dest_addr,
   output logic [3:0]      rsp_source_addr,
   output logic [4:0]      rsp_command,
   output logic [1:0]      rsp_ack_code,
   output logic            rsp_request_flag,
   output logic [7:0]      rsp_payload_length,
   output logic [7:0]      rsp_payload_byte,
   output logic            rsp_frame_end
);

   // input register holding one request byte
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   logic                has_result;
   cpd_pkg::result_type result;
   cpd_pkg::result_type rsp_data;
   logic                out_room;
   logic                step;

   // the held byte moves on when it needs no response slot, or the slot is free
   assign step        = in_valid_ff && (!has_result || out_room);
   // take a new byte whenever the input register empties this cycle
   assign req_ready   = !in_valid_ff || step;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // frame tracking and decode
   cpd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rx_byte    (in_byte_ff),
      .has_result (has_result),
      .result     (result)
   );

   // response register
   cpd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step && has_result),
      .load_data (result),
      .room      (out_room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_kind           = rsp_data.kind;
   assign rsp_dest_addr      = rsp_data.dest_addr;
   assign rsp_source_addr    = rsp_data.source_addr;
   assign rsp_command        = rsp_data.command;
   assign rsp_ack_code       = rsp_data.ack_code;
   assign rsp_request_flag   = rsp_data.request_flag;
   assign rsp_payload_length = rsp_data.payload_length;
   assign rsp_payload_byte   = rsp_data.payload_byte;
   assign rsp_frame_end      = rsp_data.frame_end;

endmodule

`default_nettype wire

// ----- verif/checksummed_packet_deframer_top_tb.sv -----
`timescale 1ns / 1ps

module checksummed_packet_deframer_top_tb;

   // clock and reset, every input known from time zero
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_kind;
   logic [3:0] rsp_dest_addr;
   logic [3:0] rsp_source_addr;
   logic [4:0] rsp_command;
   logic [1:0] rsp_ack_code;
   logic       rsp_request_flag;
   logic [7:0] rsp_payload_length;
   logic [7:0] rsp_payload_byte;
   logic       rsp_frame_end;

   checksummed_packet_deframer_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_dest_addr      (rsp_dest_addr),
      .rsp_source_addr    (rsp_source_addr),
      .rsp_command        (rsp_command),
      .rsp_ack_code       (rsp_ack_code),
      .rsp_request_flag   (rsp_request_flag),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_frame_end      (rsp_frame_end)
   );

   always #4 clock = ~clock;

   // byte stream still to be offered, and responses still owed by the block
   logic [7:0] rx_stream[$];
   cpd_pkg::result_type owed_results[$];

   // deframer state as predicted from the accepted bytes
   logic [8:0] frame_pos = '0;
   logic [7:0] hdr_bytes[3] = '{8'h00, 8'h00, 8'h00};
   logic [7:0] frame_sum = '0;

   cpd_pkg::result_type predicted;
   cpd_pkg::result_type arrived;
   cpd_pkg::result_type oldest;

   int send_gap = 0;
   int send_burst = 0;
   int recv_stall = 0;
   int recv_burst = 0;
   int hold_left = 0;
   int holds_done = 0;
   int responses_seen = 0;
   int mismatches = 0;

   // steps the deframer by one byte, returns 1 when the byte yields a response
   function automatic bit deframe_next(input logic [7:0] rx,
                                       output cpd_pkg::result_type res);
      logic [7:0] hdr_check;
      res = '0;
      if (frame_pos < cpd_pkg::POS_CHECK) begin
         // header bytes 0 to 2 are only stored and summed
         hdr_bytes[frame_pos[1:0]] = rx;
         frame_sum = frame_sum + rx;
         frame_pos = frame_pos + 9'd1;
         return 1'b0;
      end
      res.dest_addr      = hdr_bytes[0][3:0];
      res.source_addr    = hdr_bytes[0][7:4];
      res.command        = hdr_bytes[1][4:0];
      res.ack_code       = hdr_bytes[1][6:5];
      res.request_flag   = hdr_bytes[1][7];
      res.payload_length = hdr_bytes[2];
      if (frame_pos == cpd_pkg::POS_CHECK) begin
         hdr_check = cpd_pkg::HDR_SEED + hdr_bytes[0] + hdr_bytes[1] + hdr_bytes[2];
         if (rx != hdr_check) begin
            // bad header: all header fields cleared, frame dropped
            res = '0;
            res.kind = cpd_pkg::KIND_HDR_ERR;
            res.frame_end = 1'b1;
            frame_pos = '0;
            frame_sum = '0;
         end else if (hdr_bytes[2] == 8'd0) begin
            // empty frame closes on its header, no checksum byte follows
            res.kind = cpd_pkg::KIND_HDR_OK;
            res.frame_end = 1'b1;
            frame_pos = '0;
            frame_sum = '0;
         end else begin
            res.kind = cpd_pkg::KIND_HDR_OK;
            frame_sum = frame_sum + rx;
            frame_pos = cpd_pkg::POS_PAYLOAD;
         end
      end else if (frame_pos < cpd_pkg::POS_PAYLOAD + {1'b0, hdr_bytes[2]}) begin
         res.kind = cpd_pkg::KIND_PAYLOAD;
         res.payload_byte = rx;
         frame_sum = frame_sum + rx;
         frame_pos = frame_pos + 9'd1;
      end else begin
         res.kind = (rx == frame_sum) ? cpd_pkg::KIND_PKT_OK : cpd_pkg::KIND_PKT_ERR;
         res.frame_end = 1'b1;
         frame_pos = '0;
         frame_sum = '0;
      end
      return 1'b1;
   endfunction

   // idle length for one side: mostly none or short, now and then long,
   // with occasional stretches of no idling at all
   function automatic int next_gap(inout int burst_left);
      int roll;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         burst_left = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // appends one frame, optionally with a corrupted header check or checksum
   task automatic add_frame(input logic [7:0] addr, input logic [7:0] cmd,
                            input logic [7:0] len, input bit bad_hdr, input bit bad_sum);
      logic [7:0] check;
      logic [7:0] sum;
      logic [7:0] pay;
      int i;
      check = cpd_pkg::HDR_SEED + addr + cmd + len;
      if (bad_hdr) check = check + 8'($urandom_range(1, 255));
      rx_stream.push_back(addr);
      rx_stream.push_back(cmd);
      rx_stream.push_back(len);
      rx_stream.push_back(check);
      if (bad_hdr) return;
      sum = addr + cmd + len + check;
      for (i = 0; i < len; i++) begin
         pay = 8'($urandom_range(0, 255));
         rx_stream.push_back(pay);
         sum = sum + pay;
      end
      if (len != 8'd0) begin
         if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
         rx_stream.push_back(sum);
      end
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   // request driver: holds each byte until accepted, then idles at random
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_rx_byte <= 8'h00;
      end else begin
         if (req_valid && req_ready) begin
            if (deframe_next(req_rx_byte, predicted)) owed_results.push_back(predicted);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (rx_stream.size() > 0) begin
               req_valid <= 1'b1;
               req_rx_byte <= rx_stream.pop_front();
               send_gap = next_gap(send_burst);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and ready driver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            responses_seen++;
            arrived.kind           = rsp_kind;
            arrived.dest_addr      = rsp_dest_addr;
            arrived.source_addr    = rsp_source_addr;
            arrived.command        = rsp_command;
            arrived.ack_code       = rsp_ack_code;
            arrived.request_flag   = rsp_request_flag;
            arrived.payload_length = rsp_payload_length;
            arrived.payload_byte   = rsp_payload_byte;
            arrived.frame_end      = rsp_frame_end;
            if (owed_results.size() == 0) begin
               $error("response with no request outstanding, kind %0d", arrived.kind);
               mismatches++;
            end else begin
               oldest = owed_results.pop_front();
               check_field("kind", oldest.kind, arrived.kind);
               check_field("dest_addr", oldest.dest_addr, arrived.dest_addr);
               check_field("source_addr", oldest.source_addr, arrived.source_addr);
               check_field("command", oldest.command, arrived.command);
               check_field("ack_code", oldest.ack_code, arrived.ack_code);
               check_field("request_flag", oldest.request_flag, arrived.request_flag);
               check_field("payload_length", oldest.payload_length,
                           arrived.payload_length);
               check_field("payload_byte", oldest.payload_byte, arrived.payload_byte);
               check_field("frame_end", oldest.frame_end, arrived.frame_end);
            end
         end
         // long hold-offs so the block backs up and drops req_ready
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (holds_done < 2 && responses_seen >= 150 + holds_done * 400) begin
            holds_done++;
            hold_left = 300;
            rsp_ready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            recv_stall = next_gap(recv_burst);
         end
      end
   end

   // stimulus, reset and end of run
   initial begin : stimulus
      int roll;
      int len_roll;
      logic [7:0] len;
      bit long_done;
      long_done = 1'b0;

      // directed frames
      add_frame(8'h00, 8'h00, 8'd0, 1'b0, 1'b0);   // empty frame, all fields low
      add_frame(8'hFF, 8'hFF, 8'd1, 1'b0, 1'b0);   // address and command fields high, single payload byte
      add_frame(8'h5A, 8'hA5, 8'd3, 1'b1, 1'b0);   // header check mismatch
      add_frame(8'hA5, 8'h5A, 8'd2, 1'b0, 1'b1);   // checksum mismatch

      // random frames, mostly well formed, with some noise and broken ones
      while (rx_stream.size() < 1021) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            repeat ($urandom_range(1, 4)) rx_stream.push_back(8'($urandom_range(0, 255)));
         end else begin
            len_roll = $urandom_range(0, 99);
            if (!long_done && rx_stream.size() > 500) begin
               len = 8'd255;   // full length frame once
               long_done = 1'b1;
            end else if (len_roll < 12) len = 8'd0;
            else if (len_roll < 97) len = 8'($urandom_range(1, 8));
            else len = 8'($urandom_range(9, 255));
            add_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                      $urandom_range(0, 19) == 0, $urandom_range(0, 9) == 0);
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // drain: wait until all bytes are taken and all responses are in, then give the verdict
      while (rx_stream.size() != 0 || req_valid || owed_results.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(6_000_000);
      $display("Verification failed");
      $finish;
   end

endmodule
